### design/ilad_pkg.sv
// Shared types and codes for the interrupt level allocator and dispatcher.
package ilad_pkg;

   // Fixed widths of the transfer fields and registers
   localparam int ACTION_W = 2;
   localparam int IRQ_W    = 8;
   localparam int WORD_W   = 64;
   localparam int LEVEL_W  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W    = 6;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC    = 2'd0,
      ACT_RELEASE  = 2'd1,
      ACT_DISPATCH = 2'd2,
      ACT_UNUSED   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOTHING   = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_DEVICE  = 2'd0,
      KIND_RESCHED = 2'd1,
      KIND_CALL    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESERVED_TOP = 3'd0,
      CSR_IPI_ENABLE   = 3'd1,
      CSR_RESCHED_A    = 3'd2,
      CSR_RESCHED_B    = 3'd3,
      CSR_CALL_A       = 3'd4,
      CSR_CALL_B       = 3'd5
   } csr_index_type;

   // Test applied by the shared probe unit
   typedef enum logic [1:0] {
      PROBE_FREE  = 2'd0,
      PROBE_MATCH = 2'd1,
      PROBE_PEND  = 2'd2,
      PROBE_OFF   = 2'd3
   } probe_mode_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] reserved_top;
      logic               ipi_enable;
      logic [LEVEL_W-1:0] resched_a_level;
      logic [LEVEL_W-1:0] resched_b_level;
      logic [LEVEL_W-1:0] call_a_level;
      logic [LEVEL_W-1:0] call_b_level;
   } cfg_type;

   typedef struct packed {
      logic rd_en;
      logic set_en;
      logic clr_en;
   } tab_cmd_type;

   typedef struct packed {
      status_type         status;
      kind_type           kind;
      logic [LEVEL_W-1:0] level;
      logic [IRQ_W-1:0]   irq_out;
      logic               irq_valid;
      logic               clear_pending;
   } result_type;

   localparam result_type RES_IDLE = '{
      status: STAT_NOTHING, kind: KIND_DEVICE, level: '0,
      irq_out: '0, irq_valid: 1'b0, clear_pending: 1'b0
   };

endpackage

### design/ilad_if.sv
// Request and response channel interfaces.
interface ilad_req_if;
   import ilad_pkg::*;
   logic               valid;
   logic               ready;
   logic [ACTION_W-1:0] action;
   logic [IRQ_W-1:0]   irq_in;
   logic [WORD_W-1:0]  pending_word;
   logic [WORD_W-1:0]  mask_word;
   logic               bank;

   modport source (output valid, action, irq_in, pending_word, mask_word, bank,
                   input ready);
   modport sink   (input valid, action, irq_in, pending_word, mask_word, bank,
                   output ready);
endinterface

interface ilad_rsp_if;
   import ilad_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [1:0]         kind;
   logic [LEVEL_W-1:0] level;
   logic [IRQ_W-1:0]   irq_out;
   logic               irq_valid;
   logic               clear_pending;

   modport source (output valid, status, kind, level, irq_out, irq_valid, clear_pending,
                   input ready);
   modport sink   (input valid, status, kind, level, irq_out, irq_valid, clear_pending,
                   output ready);
endinterface

### design/interrupt_level_alloc_dispatch.sv
// Allocate: probes the entries above reserved_top, one per cycle.
// Release: each entry takes a table memory read and a compare.
// Dispatch: ends at the IPI check on a hit or nothing pending, else scans levels top down.
// One transfer at a time; results leave through an output register.
// Synchronous reset frees every level and loads register defaults.
// Top level: configuration registers, sequencer, shared probe, table, output register.
module interrupt_level_alloc_dispatch #(
   parameter int LEVELS   = 64,
   parameter int IRQ_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   ilad_req_if.sink                       req_chan,
   ilad_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [ilad_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ilad_pkg::CSR_W-1:0]     csr_wdata
);
   import ilad_pkg::*;

   localparam int LW = $clog2(LEVELS);

   cfg_type             cfg_ff, cfg_in;
   tab_cmd_type         tab_cmd;
   logic [LW-1:0]       tab_addr;
   logic [IRQ_BITS-1:0] tab_wirq;
   logic                tab_entry_valid;
   logic [IRQ_BITS-1:0] tab_rd_irq;
   probe_mode_type      probe_mode;
   logic                probe_pend_bit;
   logic [IRQ_BITS-1:0] probe_key;
   logic                probe_hit;
   logic                res_valid;
   logic                res_ready;
   result_type          res;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RESERVED_TOP: cfg_in.reserved_top    = csr_wdata;
            CSR_IPI_ENABLE:   cfg_in.ipi_enable      = csr_wdata[0];
            CSR_RESCHED_A:    cfg_in.resched_a_level = csr_wdata;
            CSR_RESCHED_B:    cfg_in.resched_b_level = csr_wdata;
            CSR_CALL_A:       cfg_in.call_a_level    = csr_wdata;
            CSR_CALL_B:       cfg_in.call_b_level    = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reserved_top    <= LEVEL_W'(6);
         cfg_ff.ipi_enable      <= 1'b1;
         cfg_ff.resched_a_level <= LEVEL_W'(0);
         cfg_ff.resched_b_level <= LEVEL_W'(1);
         cfg_ff.call_a_level    <= LEVEL_W'(2);
         cfg_ff.call_b_level    <= LEVEL_W'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ilad_ctrl #(.LEVELS(LEVELS), .IRQ_BITS(IRQ_BITS)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_action      (req_chan.action),
      .req_irq         (req_chan.irq_in),
      .req_pending     (req_chan.pending_word),
      .req_mask        (req_chan.mask_word),
      .req_bank        (req_chan.bank),
      .tab_cmd         (tab_cmd),
      .tab_addr        (tab_addr),
      .tab_wirq        (tab_wirq),
      .tab_entry_valid (tab_entry_valid),
      .tab_rd_irq      (tab_rd_irq),
      .probe_mode      (probe_mode),
      .probe_pend_bit  (probe_pend_bit),
      .probe_key       (probe_key),
      .probe_hit       (probe_hit),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res)
   );

   ilad_probe #(.IRQ_BITS(IRQ_BITS)) u_probe (
      .mode        (probe_mode),
      .entry_valid (tab_entry_valid),
      .entry_irq   (tab_rd_irq),
      .key         (probe_key),
      .pend_bit    (probe_pend_bit),
      .hit         (probe_hit)
   );

   ilad_table #(.LEVELS(LEVELS), .IRQ_BITS(IRQ_BITS)) u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (tab_cmd),
      .addr        (tab_addr),
      .wr_irq      (tab_wirq),
      .entry_valid (tab_entry_valid),
      .rd_irq      (tab_rd_irq)
   );

   // Output register: load a finished result when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.kind          = rsp_data_ff.kind;
   assign rsp_chan.level         = rsp_data_ff.level;
   assign rsp_chan.irq_out       = rsp_data_ff.irq_out;
   assign rsp_chan.irq_valid     = rsp_data_ff.irq_valid;
   assign rsp_chan.clear_pending = rsp_data_ff.clear_pending;

endmodule

### design/ilad_table.sv
// Level table: valid flags in flops, irq numbers in a one-port memory.
module ilad_table #(
   parameter int LEVELS   = 64,
   parameter int IRQ_BITS = 8,
   localparam int LW = $clog2(LEVELS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ilad_pkg::tab_cmd_type cmd,
   input  logic [LW-1:0]         addr,
   input  logic [IRQ_BITS-1:0]   wr_irq,
   output logic                  entry_valid,
   output logic [IRQ_BITS-1:0]   rd_irq
);
   import ilad_pkg::*;

   logic [LEVELS-1:0]   valid_ff;
   logic [IRQ_BITS-1:0] irq_mem [LEVELS];
   logic [IRQ_BITS-1:0] rd_irq_ff;

   // Set on allocate, drop on release, clear all on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.set_en) begin
         valid_ff[addr] <= 1'b1;
      end else if (cmd.clr_en) begin
         valid_ff[addr] <= 1'b0;
      end
   end

   // Write irq on allocate, register the read port
   always_ff @(posedge clock) begin
      if (cmd.set_en) begin
         irq_mem[addr] <= wr_irq;
      end
      if (cmd.rd_en) begin
         rd_irq_ff <= irq_mem[addr];
      end
   end

   assign entry_valid = valid_ff[addr];
   assign rd_irq      = rd_irq_ff;

endmodule

### design/ilad_probe.sv
// Shared per-entry test unit used by every scan of the sequencer.
module ilad_probe #(
   parameter int IRQ_BITS = 8
) (
   input  ilad_pkg::probe_mode_type mode,
   input  logic                     entry_valid,
   input  logic [IRQ_BITS-1:0]      entry_irq,
   input  logic [IRQ_BITS-1:0]      key,
   input  logic                     pend_bit,
   output logic                     hit
);
   import ilad_pkg::*;

   // Pick the test for the current scan
   always_comb begin
      case (mode)
         PROBE_FREE:  hit = !entry_valid;
         PROBE_MATCH: hit = entry_valid && (entry_irq == key);
         PROBE_PEND:  hit = pend_bit;
         default:     hit = 1'b0;
      endcase
   end

endmodule

### design/ilad_ctrl.sv
// Sequencer: walks the level table entry by entry and builds the result.
module ilad_ctrl #(
   parameter int LEVELS   = 64,
   parameter int IRQ_BITS = 8,
   localparam int LW = $clog2(LEVELS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ilad_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ilad_pkg::ACTION_W-1:0] req_action,
   input  logic [ilad_pkg::IRQ_W-1:0] req_irq,
   input  logic [ilad_pkg::WORD_W-1:0] req_pending,
   input  logic [ilad_pkg::WORD_W-1:0] req_mask,
   input  logic                       req_bank,
   output ilad_pkg::tab_cmd_type      tab_cmd,
   output logic [LW-1:0]              tab_addr,
   output logic [IRQ_BITS-1:0]        tab_wirq,
   input  logic                       tab_entry_valid,
   input  logic [IRQ_BITS-1:0]        tab_rd_irq,
   output ilad_pkg::probe_mode_type   probe_mode,
   output logic                       probe_pend_bit,
   output logic [IRQ_BITS-1:0]        probe_key,
   input  logic                       probe_hit,
   output logic                       res_valid,
   input  logic                       res_ready,
   output ilad_pkg::result_type       res
);
   import ilad_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_REL_RD,
      S_REL_CHK,
      S_IPI,
      S_SCAN,
      S_MAP,
      S_DONE
   } state_type;

   localparam logic [WORD_W-1:0] LEVEL_MASK =
      (LEVELS >= WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << LEVELS) - WORD_W'(1));
   localparam logic [LW-1:0]      LAST_IDX   = LW'(LEVELS - 1);

   state_type           state_ff, state_in;
   logic [IRQ_BITS-1:0] key_ff, key_in;
   logic [WORD_W-1:0]   pend_ff, pend_in;
   logic                bank_ff, bank_in;
   logic [LW-1:0]       idx_ff, idx_in;
   result_type          res_ff, res_in;

   logic [LEVEL_W:0]    start_lvl;
   logic                range_empty;
   logic                ipi_on;
   logic                accept;

   assign start_lvl   = {1'b0, cfg.reserved_top} + (LEVEL_W+1)'(1);
   assign range_empty = start_lvl >= (LEVEL_W+1)'(LEVELS);
   assign ipi_on      = !bank_ff && cfg.ipi_enable;
   assign accept      = req_valid && req_ready;

   assign req_ready      = (state_ff == S_IDLE);
   assign res_valid      = (state_ff == S_DONE);
   assign res            = res_ff;
   assign tab_addr       = idx_ff;
   assign tab_wirq       = key_ff;
   assign probe_key      = key_ff;
   assign probe_pend_bit = pend_ff[LEVEL_W'(idx_ff)];

   // Next state and result
   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      pend_in    = pend_ff;
      bank_in    = bank_ff;
      idx_in     = idx_ff;
      res_in     = res_ff;
      tab_cmd    = '0;
      probe_mode = PROBE_OFF;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in  = IRQ_BITS'(req_irq);
               pend_in = req_pending & req_mask & LEVEL_MASK;
               bank_in = req_bank;
               idx_in  = start_lvl[LW-1:0];
               res_in  = RES_IDLE;
               case (action_type'(req_action))
                  ACT_ALLOC: begin
                     if (range_empty) begin
                        res_in.status = STAT_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  ACT_RELEASE: begin
                     if (range_empty) begin
                        res_in.status = STAT_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_REL_RD;
                     end
                  end
                  ACT_DISPATCH: state_in = S_IPI;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         // Take the first free entry
         S_ALLOC: begin
            probe_mode = PROBE_FREE;
            if (probe_hit) begin
               tab_cmd.set_en = 1'b1;
               res_in.status  = STAT_OK;
               res_in.level   = LEVEL_W'(idx_ff);
               state_in       = S_DONE;
            end else if (idx_ff == LAST_IDX) begin
               res_in.status = STAT_FULL;
               state_in      = S_DONE;
            end else begin
               idx_in = idx_ff + LW'(1);
            end
         end
         S_REL_RD: begin
            tab_cmd.rd_en = 1'b1;
            state_in      = S_REL_CHK;
         end
         // Free the entry that holds the irq
         S_REL_CHK: begin
            probe_mode = PROBE_MATCH;
            if (probe_hit) begin
               tab_cmd.clr_en = 1'b1;
               res_in.status  = STAT_OK;
               res_in.level   = LEVEL_W'(idx_ff);
               state_in       = S_DONE;
            end else if (idx_ff == LAST_IDX) begin
               res_in.status = STAT_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = S_REL_RD;
            end
         end
         // Check the IPI levels in fixed order, else start the top-down search
         S_IPI: begin
            state_in = S_DONE;
            if (pend_ff == '0) begin
               res_in = RES_IDLE;
            end else begin
               res_in.status        = STAT_OK;
               res_in.clear_pending = 1'b1;
               if (ipi_on && pend_ff[cfg.resched_a_level]) begin
                  res_in.kind  = KIND_RESCHED;
                  res_in.level = cfg.resched_a_level;
               end else if (ipi_on && pend_ff[cfg.resched_b_level]) begin
                  res_in.kind  = KIND_RESCHED;
                  res_in.level = cfg.resched_b_level;
               end else if (ipi_on && pend_ff[cfg.call_a_level]) begin
                  res_in.kind  = KIND_CALL;
                  res_in.level = cfg.call_a_level;
               end else if (ipi_on && pend_ff[cfg.call_b_level]) begin
                  res_in.kind  = KIND_CALL;
                  res_in.level = cfg.call_b_level;
               end else begin
                  res_in.clear_pending = bank_ff;
                  idx_in               = LAST_IDX;
                  state_in             = S_SCAN;
               end
            end
         end
         // Find the highest pending level; the word is known nonzero
         S_SCAN: begin
            probe_mode = PROBE_PEND;
            if (probe_hit) begin
               tab_cmd.rd_en = 1'b1;
               res_in.level  = LEVEL_W'(idx_ff);
               state_in      = S_MAP;
            end else begin
               idx_in = idx_ff - LW'(1);
            end
         end
         // Map the level through the table
         S_MAP: begin
            res_in.irq_valid = tab_entry_valid;
            res_in.irq_out   = tab_entry_valid ? IRQ_W'(tab_rd_irq) : '0;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff  <= key_in;
      pend_ff <= pend_in;
      bank_ff <= bank_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
   end

endmodule

### design/ilad_checker.sv
// Port-level checks for the interrupt level allocator, bound to the top level.
module ilad_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic [1:0] status,
   input logic [1:0] kind,
   input logic [5:0] level,
   input logic       irq_valid,
   input logic       clear_pending
);
   import ilad_pkg::*;

   // Reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One transfer at a time: busy after a request is taken
   assert property (@(posedge clock) (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in work");

   // Nothing pending carries no other information
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == STAT_NOTHING) |->
         (kind == KIND_DEVICE && level == '0 && !irq_valid && !clear_pending))
      else $error("nothing-pending result with nonzero fields");

   // An IPI hit always clears and never maps an irq
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind == KIND_RESCHED || kind == KIND_CALL)) |->
         (status == STAT_OK && clear_pending && !irq_valid))
      else $error("IPI result fields inconsistent");

   // Failed allocate or release reports level zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status == STAT_FULL || status == STAT_NOT_FOUND)) |->
         (level == '0 && kind == KIND_DEVICE && !clear_pending))
      else $error("failed table operation with nonzero level");

endmodule

bind interrupt_level_alloc_dispatch ilad_checker u_ilad_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .status        (rsp_chan.status),
   .kind          (rsp_chan.kind),
   .level         (rsp_chan.level),
   .irq_valid     (rsp_chan.irq_valid),
   .clear_pending (rsp_chan.clear_pending)
);
